>>> rtl/auth_nonce_pair_collector_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nonce pair collector
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef AUTH_NONCE_PAIR_COLLECTOR_TOP_MACROS_SVH
`define AUTH_NONCE_PAIR_COLLECTOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ANPC_ASSERT_NOW(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);
// next-cycle implication
`define ANPC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);
`else
`define ANPC_ASSERT_NOW(label, clk, rst, pre, post, msg)
`define ANPC_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

>>> rtl/anpc_pkg.sv
// ----------------------------------------------------------------------------
// anpc_pkg
// Shared widths, codes and structs of the nonce pair collector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package anpc_pkg;

  localparam int STORE_DEPTH = 128;
  localparam int MAX_OPENED  = 128;
  localparam int OPEN_LIMIT  = (MAX_OPENED < STORE_DEPTH) ? MAX_OPENED : STORE_DEPTH;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int SECTOR_W    = 6;
  localparam int WORD_W      = 32;

  typedef enum logic [1:0] {
    OUT_PAIRED  = 2'd0,
    OUT_OPENED  = 2'd1,
    OUT_DROPPED = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // search transaction walking down the cell row
  typedef struct packed {
    logic                active;
    logic [SECTOR_W-1:0] sector;
    logic                key_b;
    logic                found;
    logic [IDX_W-1:0]    idx;
    logic [WORD_W-1:0]   nt;
    logic [WORD_W-1:0]   nr;
    logic [WORD_W-1:0]   ar;
  } token_t;

  // entry write broadcast to all cells
  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    idx;
    logic [SECTOR_W-1:0] sector;
    logic                key_b;
    logic [WORD_W-1:0]   nt;
    logic [WORD_W-1:0]   nr;
    logic [WORD_W-1:0]   ar;
  } wr_t;

endpackage

>>> rtl/anpc_cell.sv
// ----------------------------------------------------------------------------
// anpc_cell
// One table entry plus one stage of the search row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module anpc_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [anpc_pkg::IDX_W-1:0]  cell_index,
  input  logic [anpc_pkg::CNT_W-1:0]  opened_count,
  input  anpc_pkg::wr_t               wr,
  input  anpc_pkg::token_t            tok_in,
  output anpc_pkg::token_t            tok_out
);
  import anpc_pkg::*;

  logic [SECTOR_W-1:0] sector;
  logic                key_b;
  logic                filled;
  logic [WORD_W-1:0]   nt;
  logic [WORD_W-1:0]   nr;
  logic [WORD_W-1:0]   ar;

  logic   opened;
  logic   hit;
  token_t tok_next;

  assign opened = {1'b0, cell_index} < {{(CNT_W-IDX_W){1'b0}}, opened_count[IDX_W-1:0]}
                  || opened_count[CNT_W-1];
  assign hit = tok_in.active && !tok_in.found && opened && !filled
               && (sector == tok_in.sector) && (key_b == tok_in.key_b);

  always_comb begin
    tok_next = tok_in;
    if (hit) begin
      tok_next.found = 1'b1;
      tok_next.idx   = cell_index;
      tok_next.nt    = nt;
      tok_next.nr    = nr;
      tok_next.ar    = ar;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  // entry storage, undefined until opened
  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == cell_index)) begin
      sector <= wr.sector;
      key_b  <= wr.key_b;
      filled <= 1'b0;
      nt     <= wr.nt;
      nr     <= wr.nr;
      ar     <= wr.ar;
    end else if (hit) begin
      filled <= 1'b1;
    end
  end

endmodule

>>> rtl/anpc_chain.sv
// ----------------------------------------------------------------------------
// anpc_chain
// Row of entry cells; a search transaction advances one cell per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module anpc_chain (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [anpc_pkg::CNT_W-1:0]  opened_count,
  input  anpc_pkg::wr_t               wr,
  input  anpc_pkg::token_t            head,
  output anpc_pkg::token_t            tail
);
  import anpc_pkg::*;

  token_t link [STORE_DEPTH+1];

  assign link[0] = head;
  assign tail    = link[STORE_DEPTH];

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    anpc_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .cell_index   (IDX_W'(i)),
      .opened_count (opened_count),
      .wr           (wr),
      .tok_in       (link[i]),
      .tok_out      (link[i+1])
    );
  end

endmodule

>>> rtl/auth_nonce_pair_collector_top.sv
// ----------------------------------------------------------------------------
// auth_nonce_pair_collector_top
// Pairs captured authentication events by sector and key type.
// ----------------------------------------------------------------------------
// Each accepted event transaction is matched against the entry table in order
// of opening. The table is a row of 128 cells, each holding one entry; the
// search walks the row one cell per cycle, the first cell loaded at the
// accepting edge; the transaction is captured off the tail into the held
// register, then the result register is loaded once it is free, and the next
// event is taken the cycle after the result register is loaded, so events are
// handled one at a time, never overlapped.
// The oldest unfilled entry with the same sector and key type is marked
// filled and the full pair is returned (outcome paired). With no match a new
// entry is opened while fewer than MAX_OPENED entries exist (outcome opened);
// otherwise the event is dropped. Exactly one result per event. No clearing
// pass is needed after reset: entries are only looked at below the open count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "auth_nonce_pair_collector_top_macros.svh"

module auth_nonce_pair_collector_top (
  input  logic                          clk,
  input  logic                          rst,
  // event channel
  input  logic                          evt_valid,
  output logic                          evt_ready,
  input  logic [anpc_pkg::SECTOR_W-1:0] sector,
  input  logic                          key_b,
  input  logic [anpc_pkg::WORD_W-1:0]   tag_nonce,
  input  logic [anpc_pkg::WORD_W-1:0]   reader_nonce,
  input  logic [anpc_pkg::WORD_W-1:0]   reader_answer,
  // result channel
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [1:0]                    outcome,
  output logic [anpc_pkg::IDX_W-1:0]    entry_index,
  output logic [anpc_pkg::CNT_W-1:0]    pairs_total,
  output logic [anpc_pkg::SECTOR_W-1:0] pair_sector,
  output logic                          pair_key_b,
  output logic [anpc_pkg::WORD_W-1:0]   first_nt,
  output logic [anpc_pkg::WORD_W-1:0]   first_nr,
  output logic [anpc_pkg::WORD_W-1:0]   first_ar,
  output logic [anpc_pkg::WORD_W-1:0]   second_nt,
  output logic [anpc_pkg::WORD_W-1:0]   second_nr,
  output logic [anpc_pkg::WORD_W-1:0]   second_ar
);
  import anpc_pkg::*;

  localparam logic [CNT_W-1:0] OPEN_LIMIT_C = CNT_W'(OPEN_LIMIT);

  state_t              state;
  logic [CNT_W-1:0]    opened_count;
  logic [CNT_W-1:0]    pairs_count;

  // current event, held for the whole search
  logic [SECTOR_W-1:0] ev_sector;
  logic                ev_key_b;
  logic [WORD_W-1:0]   ev_nt;
  logic [WORD_W-1:0]   ev_nr;
  logic [WORD_W-1:0]   ev_ar;

  token_t head;
  token_t tail;
  token_t held;   // search transaction captured off the end of the row
  wr_t    wr;

  logic accept;
  logic commit;
  logic open_ok;

  assign evt_ready = (state == ST_IDLE);
  assign accept    = evt_valid && evt_ready;
  // result register free, or being emptied this cycle
  assign commit    = (state == ST_DONE) && (!res_valid || res_ready);
  assign open_ok   = opened_count < OPEN_LIMIT_C;

  // new search enters the first cell on acceptance
  always_comb begin
    head        = '0;
    head.active = accept;
    head.sector = sector;
    head.key_b  = key_b;
  end

  // open a new entry when the search missed and there is room
  always_comb begin
    wr.en     = commit && !held.found && open_ok;
    wr.idx    = opened_count[IDX_W-1:0];
    wr.sector = ev_sector;
    wr.key_b  = ev_key_b;
    wr.nt     = ev_nt;
    wr.nr     = ev_nr;
    wr.ar     = ev_ar;
  end

  anpc_chain u_chain (
    .clk          (clk),
    .rst          (rst),
    .opened_count (opened_count),
    .wr           (wr),
    .head         (head),
    .tail         (tail)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      ev_sector <= sector;
      ev_key_b  <= key_b;
      ev_nt     <= tag_nonce;
      ev_nr     <= reader_nonce;
      ev_ar     <= reader_answer;
    end
    if ((state == ST_SCAN) && tail.active) begin
      held <= tail;
    end
  end

  // sequencer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      opened_count <= '0;
      pairs_count  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tail.active) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (commit) begin
            state <= ST_IDLE;
            if (held.found) begin
              pairs_count <= pairs_count + 1'b1;
            end else if (open_ok) begin
              opened_count <= opened_count + 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (commit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      pair_sector <= '0;
      pair_key_b  <= 1'b0;
      first_nt    <= '0;
      first_nr    <= '0;
      first_ar    <= '0;
      second_nt   <= '0;
      second_nr   <= '0;
      second_ar   <= '0;
      pairs_total <= pairs_count;
      if (held.found) begin
        outcome     <= OUT_PAIRED;
        entry_index <= held.idx;
        pairs_total <= pairs_count + 1'b1;
        pair_sector <= ev_sector;
        pair_key_b  <= ev_key_b;
        first_nt    <= held.nt;
        first_nr    <= held.nr;
        first_ar    <= held.ar;
        second_nt   <= ev_nt;
        second_nr   <= ev_nr;
        second_ar   <= ev_ar;
      end else if (open_ok) begin
        outcome     <= OUT_OPENED;
        entry_index <= opened_count[IDX_W-1:0];
      end else begin
        outcome     <= OUT_DROPPED;
        entry_index <= '0;
      end
    end
  end

  // a search transaction only leaves the row while the sequencer waits for it
  `ANPC_ASSERT_NOW(a_tail_in_scan, clk, rst, tail.active, state == ST_SCAN,
    "search left the cell row outside of a scan")
  // open count never passes the table limit
  `ANPC_ASSERT_NOW(a_open_limit, clk, rst, 1'b1, opened_count <= OPEN_LIMIT_C,
    "open count beyond limit")
  // every pair consumes one opened entry
  `ANPC_ASSERT_NOW(a_pairs_le_open, clk, rst, 1'b1, pairs_count <= opened_count,
    "more pairs than opened entries")
  // a committed event always shows a result next cycle
  `ANPC_ASSERT_NEXT(a_commit_result, clk, rst, commit, res_valid,
    "committed event produced no result")

endmodule
